/* sv/plm_pkg.sv */
// plm_pkg: shared types and codes for the posting list merge block.
// Depends on nothing; imported by posting_list_merge and the testbench.
package plm_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] doc_id;
        logic [15:0] hit_count;
        logic [31:0] position_offset;
        logic [31:0] base_a;
        logic [31:0] base_b;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_doc_id;
        logic [15:0] out_hit_count;
        logic [31:0] out_offset;
        logic        last;
        logic        dropped;
    } out_item_t;

    // One stored list entry
    typedef struct packed {
        logic [31:0] doc_id;
        logic [15:0] hit_count;
        logic [31:0] offset;
    } entry_t;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } merge_state_t;

endpackage

/* sv/plm_ram.sv */
// plm_ram: generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module plm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/posting_list_merge.sv */
// posting_list_merge: top level of the two-way sorted posting list merge.
// Depends on plm_pkg (types, request codes) and plm_ram (list storage).

// Load items (req_type A or B) append one entry to list A or list B; while the
// block is idle, loads stream at one per cycle. Each list lives in its own
// RAM of LIST_DEPTH entries; a load into a full list is dropped and sets a
// sticky flag that is reported on every result of the next start. A start item
// latches both base offsets; on the cycle it is accepted the block reads the
// head of each list, and once in the merge state it emits one merged entry per
// cycle unless a result waits on m_ready (ascending doc id, list B first on a
// tie), the single read port of each list RAM setting that pace. A start
// therefore occupies the block until its last result is in the output register,
// stalling while a result waits on m_ready; no item is accepted while the merge
// runs. A start with both lists empty emits nothing and returns to idle at once.
// The emitted offset is entry offset - first offset of its list + base of its
// list, mod 2^32; the base minus first term is formed once at start so each
// result costs one add. The final result of a start has last set. Both lists
// are empty after a start. Results sit in an output register, so a load or
// start may be accepted while the last result still waits for m_ready.
module posting_list_merge
    import plm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int LEFT_W = $clog2(2 * LIST_DEPTH + 1);
    localparam int ENT_W  = $bits(entry_t);

    merge_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]  i_reg, i_next;      // read position in list A
    logic [CNT_W-1:0]  j_reg, j_next;      // read position in list B
    logic [LEFT_W-1:0] left_reg, left_next; // results still to emit
    logic [31:0]       first_a_reg, first_b_reg;
    logic [31:0]       delta_a_reg, delta_b_reg;
    logic              ovf_reg, ovf_next;
    logic              drop_reg;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg;

    logic   accept, is_load_a, is_load_b, is_start;
    logic   full_a, full_b, wr_a, wr_b;
    logic   advance, a_live, b_live, take_a, pop_a, pop_b;
    logic   start_empty;
    entry_t wr_entry, head_a, head_b, head_sel;
    logic [31:0]       delta_sel;
    logic [LEFT_W-1:0] total;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign accept    = s_valid && s_ready;
    assign is_load_a = accept && (s_item.req_type == REQ_LOAD_A);
    assign is_load_b = accept && (s_item.req_type == REQ_LOAD_B);
    assign is_start  = accept && (s_item.req_type == REQ_START);

    assign full_a = (cnt_a_reg == CNT_W'(LIST_DEPTH));
    assign full_b = (cnt_b_reg == CNT_W'(LIST_DEPTH));
    assign wr_a   = is_load_a && !full_a;
    assign wr_b   = is_load_b && !full_b;

    assign wr_entry.doc_id    = s_item.doc_id;
    assign wr_entry.hit_count = s_item.hit_count;
    assign wr_entry.offset    = s_item.position_offset;

    assign total       = LEFT_W'(cnt_a_reg) + LEFT_W'(cnt_b_reg);
    assign start_empty = (total == '0);

    // ------------------------------------------------------------------
    // List storage. Read address is the next head index, so the registered RAM
    // output always holds the entry at the current head.
    // ------------------------------------------------------------------
    plm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (i_next[IDX_W-1:0]),
        .rd_data (head_a)
    );

    plm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (j_next[IDX_W-1:0]),
        .rd_data (head_b)
    );

    // ------------------------------------------------------------------
    // Head compare; B wins ties
    // ------------------------------------------------------------------
    assign a_live = (i_reg < cnt_a_reg);
    assign b_live = (j_reg < cnt_b_reg);
    assign take_a = a_live && (!b_live || (head_a.doc_id < head_b.doc_id));

    assign head_sel  = take_a ? head_a : head_b;
    assign delta_sel = take_a ? delta_a_reg : delta_b_reg;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (is_start && !start_empty) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (advance && (left_reg == LEFT_W'(1))) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready = 1'b0;
        advance = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_MERGE: begin
                advance = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign pop_a = advance && take_a;
    assign pop_b = advance && !take_a;

    // ------------------------------------------------------------------
    // Counter and flag updates
    // ------------------------------------------------------------------
    always_comb begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        left_next  = left_reg;
        ovf_next   = ovf_reg;

        if (wr_a) begin
            cnt_a_next = cnt_a_reg + CNT_W'(1);
        end
        if (wr_b) begin
            cnt_b_next = cnt_b_reg + CNT_W'(1);
        end
        if ((is_load_a && full_a) || (is_load_b && full_b)) begin
            ovf_next = 1'b1;
        end
        if (is_start) begin
            ovf_next  = 1'b0;
            left_next = total;
        end
        if (pop_a) begin
            i_next = i_reg + CNT_W'(1);
        end
        if (pop_b) begin
            j_next = j_reg + CNT_W'(1);
        end
        if (advance) begin
            left_next = left_reg - LEFT_W'(1);
        end
        // Lists are emptied at the end of a merge (an empty start finds them empty already)
        if ((state_reg == ST_MERGE) && (state_next == ST_IDLE)) begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            i_next     = '0;
            j_next     = '0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_a_reg   <= '0;
            cnt_b_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            left_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_a_reg   <= cnt_a_next;
            cnt_b_reg   <= cnt_b_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            left_reg    <= left_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and side registers, no reset needed
    always_ff @(posedge aclk) begin
        if (wr_a && (cnt_a_reg == '0)) begin
            first_a_reg <= s_item.position_offset;
        end
        if (wr_b && (cnt_b_reg == '0)) begin
            first_b_reg <= s_item.position_offset;
        end
        if (is_start) begin
            delta_a_reg <= s_item.base_a - first_a_reg;
            delta_b_reg <= s_item.base_b - first_b_reg;
            drop_reg    <= ovf_reg;
        end
        if (advance) begin
            m_item_reg.out_doc_id    <= head_sel.doc_id;
            m_item_reg.out_hit_count <= head_sel.hit_count;
            m_item_reg.out_offset    <= head_sel.offset + delta_sel;
            m_item_reg.last          <= (left_reg == LEFT_W'(1));
            m_item_reg.dropped       <= drop_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_a_reg <= CNT_W'(LIST_DEPTH)) && (cnt_b_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_read_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> ((i_reg <= cnt_a_reg) && (j_reg <= cnt_b_reg)))
        else $error("merge read position past list end");

    a_left_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |->
            (left_reg == (LEFT_W'(cnt_a_reg - i_reg) + LEFT_W'(cnt_b_reg - j_reg))))
        else $error("remaining count out of step with read positions");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (left_reg == LEFT_W'(1))) |=>
            ((state_reg == ST_IDLE) && m_item_reg.last && (cnt_a_reg == '0)))
        else $error("final result did not end the merge");

    a_no_live_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> (a_live || b_live))
        else $error("merge running with both lists exhausted");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for posting_list_merge, two sorted lists merged and rebased.
// Depends on plm_pkg (item types, request codes) and the posting_list_merge RTL.
module testbench;
    import plm_pkg::*;

    localparam int          DEPTH       = 32;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_WAIT  = 100;   // outlasts a full merge of both lists
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;  // selector the block must ignore

    // One queued request; hold makes the sender wait until every merged
    // entry already owed has come out before offering it.
    typedef struct packed {
        logic     hold;
        in_item_t req;
    } pending_req_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    posting_list_merge #(
        .LIST_DEPTH(DEPTH)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Requests waiting for the sender, and merged entries owed by the block
    pending_req_t request_q[$];
    out_item_t    merged_q[$];

    int requests_queued  = 0;
    int requests_taken   = 0;
    int batch_loads      = 0;
    int bad_results      = 0;
    int cycle_count      = 0;
    int send_idle_pct    = 25;
    int recv_idle_pct    = 47;

    // Shadow copy of both lists, their fill counts and the sticky drop flag
    entry_t list_a[DEPTH];
    entry_t list_b[DEPTH];
    int     fill_a       = 0;
    int     fill_b       = 0;
    logic   drop_pending = 1'b0;

    // Apply one accepted request to the shadow lists; a start appends the
    // whole merged, rebased sequence to merged_q.
    task automatic apply_request(input in_item_t req);
        int          ia;
        int          ib;
        int          total;
        logic        pick_a;
        logic [31:0] first_a;
        logic [31:0] first_b;
        entry_t      head;
        out_item_t   res;
        case (req.req_type)
            REQ_LOAD_A: begin
                if (fill_a < DEPTH) begin
                    list_a[fill_a] = '{req.doc_id, req.hit_count, req.position_offset};
                    fill_a++;
                end else begin
                    drop_pending = 1'b1;
                end
            end
            REQ_LOAD_B: begin
                if (fill_b < DEPTH) begin
                    list_b[fill_b] = '{req.doc_id, req.hit_count, req.position_offset};
                    fill_b++;
                end else begin
                    drop_pending = 1'b1;
                end
            end
            REQ_START: begin
                ia      = 0;
                ib      = 0;
                total   = fill_a + fill_b;
                first_a = (fill_a > 0) ? list_a[0].offset : 32'd0;
                first_b = (fill_b > 0) ? list_b[0].offset : 32'd0;
                // Only heads are compared, so unsorted lists merge in head order;
                // a tie goes to list B.
                while (ia < fill_a || ib < fill_b) begin
                    if (ia >= fill_a) pick_a = 1'b0;
                    else if (ib >= fill_b) pick_a = 1'b1;
                    else pick_a = list_a[ia].doc_id < list_b[ib].doc_id;
                    if (pick_a) begin
                        head = list_a[ia];
                        res.out_offset = head.offset - first_a + req.base_a;
                        ia++;
                    end else begin
                        head = list_b[ib];
                        res.out_offset = head.offset - first_b + req.base_b;
                        ib++;
                    end
                    res.out_doc_id    = head.doc_id;
                    res.out_hit_count = head.hit_count;
                    res.last          = (ia + ib == total);
                    res.dropped       = drop_pending;
                    merged_q.insert(merged_q.size(), res);
                end
                fill_a       = 0;
                fill_b       = 0;
                drop_pending = 1'b0;
            end
            default: ;  // unused selector: nothing happens
        endcase
    endtask

    // Sender: offers the next queued request, idling at random; every
    // accepted request goes through the shadow model in the same edge.
    always @(posedge aclk) begin : sender
        logic         offer;
        pending_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_item);
                requests_taken++;
            end
            if (!s_valid || s_ready) begin
                offer = 1'b0;
                if (request_q.size() != 0) begin
                    if (request_q[0].hold && merged_q.size() != 0) offer = 1'b0;
                    else offer = ($urandom_range(0, 99) >= send_idle_pct);
                end
                if (offer) begin
                    nxt = request_q.pop_front();
                    s_valid <= 1'b1;
                    s_item  <= nxt.req;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random backpressure, and each accepted result is checked
    // field by field against the oldest owed entry.
    always @(posedge aclk) begin : receiver
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (merged_q.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result: doc %h hits %h off %h last %b drop %b",
                                 m_item.out_doc_id, m_item.out_hit_count, m_item.out_offset,
                                 m_item.last, m_item.dropped);
                end else begin
                    want = merged_q.pop_front();
                    if (m_item.out_doc_id    !== want.out_doc_id    ||
                        m_item.out_hit_count !== want.out_hit_count ||
                        m_item.out_offset    !== want.out_offset    ||
                        m_item.last          !== want.last          ||
                        m_item.dropped       !== want.dropped) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"mismatch (exp/got): doc %h/%h hits %h/%h ",
                                      "off %h/%h last %b/%b drop %b/%b"},
                                     want.out_doc_id, m_item.out_doc_id,
                                     want.out_hit_count, m_item.out_hit_count,
                                     want.out_offset, m_item.out_offset,
                                     want.last, m_item.last,
                                     want.dropped, m_item.dropped);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_item(input logic [1:0] kind, input logic [31:0] id,
                              input logic [15:0] hits, input logic [31:0] off,
                              input logic [31:0] ba, input logic [31:0] bb,
                              input logic hold);
        pending_req_t p;
        p.hold = hold;
        p.req  = '{kind, id, hits, off, ba, bb};
        request_q.insert(request_q.size(), p);
        requests_queued++;
        if (kind != REQ_UNUSED) batch_loads++;
    endtask

    // Loads carry random base fields, starts random entry fields: both are don't-care
    task automatic queue_load(input logic [1:0] kind, input logic [31:0] id,
                              input logic [15:0] hits, input logic [31:0] off,
                              input logic hold);
        queue_item(kind, id, hits, off, $urandom, $urandom, hold);
    endtask

    task automatic queue_start(input logic [31:0] ba, input logic [31:0] bb,
                               input logic hold);
        queue_item(REQ_START, $urandom, 16'($urandom), $urandom, ba, bb, hold);
    endtask

    // Mostly short lists; now and then one near or past the list depth
    function automatic int list_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(30, 34);
        return $urandom_range(0, 5);
    endfunction

    // One batch: n_a and n_b loads interleaved at random, then a start.
    // Ids ascend from a common origin so ties across lists are common;
    // some batches load unsorted ids and some carry ignored requests.
    task automatic queue_merge_batch(input int n_a, input int n_b);
        int          ia;
        int          ib;
        logic        to_a;
        logic        hold;
        logic        shuffled;
        logic [31:0] step_max;
        logic [31:0] next_a;
        logic [31:0] next_b;
        logic [31:0] id;
        logic [32:0] sum;
        ia       = 0;
        ib       = 0;
        hold     = ($urandom_range(0, 3) == 0);
        shuffled = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 3))
            0:       step_max = 32'd2;
            1:       step_max = 32'd1000;
            2:       step_max = 32'h00ff_ffff;
            default: step_max = 32'hffff_ffff;
        endcase
        next_a = ($urandom_range(0, 1) != 0) ? $urandom : ($urandom >> 12);
        next_b = next_a;
        while (ia < n_a || ib < n_b) begin
            if ($urandom_range(0, 9) == 0)
                queue_item(REQ_UNUSED, $urandom, 16'($urandom), $urandom, $urandom,
                           $urandom, 1'b0);
            to_a = (ib >= n_b) || (ia < n_a && $urandom_range(0, 1) != 0);
            sum  = {1'b0, to_a ? next_a : next_b} + {1'b0, $urandom_range(0, step_max)};
            id   = shuffled ? $urandom : (sum[32] ? 32'hffff_ffff : sum[31:0]);
            if (to_a) begin
                next_a = id;
                ia++;
            end else begin
                next_b = id;
                ib++;
            end
            queue_load(to_a ? REQ_LOAD_A : REQ_LOAD_B, id, 16'($urandom), $urandom, hold);
            hold = 1'b0;
        end
        queue_start($urandom, $urandom, hold);
    endtask

    // Every queued request taken and every owed entry received
    task automatic wait_for_drain();
        while (requests_taken != requests_queued || merged_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin : stimulus
        int phase;

        // Directed: empty start, ignored selector
        queue_start(32'hdead_beef, 32'h1234_5678, 1'b0);
        queue_item(REQ_UNUSED, '1, '1, '1, '1, '1, 1'b0);
        // Field extremes, ties on every id (B first), offsets wrapping
        queue_load(REQ_LOAD_A, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0);
        queue_load(REQ_LOAD_A, 32'h0000_0005, 16'hffff, 32'hffff_ffff, 1'b0);
        queue_load(REQ_LOAD_A, 32'hffff_ffff, 16'h1234, 32'h0000_000a, 1'b0);
        queue_load(REQ_LOAD_B, 32'h0000_0000, 16'h0007, 32'h0000_0064, 1'b0);
        queue_load(REQ_LOAD_B, 32'h0000_0005, 16'h0008, 32'h0000_0063, 1'b0);
        queue_load(REQ_LOAD_B, 32'hffff_ffff, 16'hffff, 32'h0000_0000, 1'b0);
        queue_start(32'hffff_ffff, 32'h0000_0000, 1'b0);
        // List B alone; sender holds off until the previous merge is out
        queue_load(REQ_LOAD_B, 32'h0000_0003, 16'h00aa, 32'h8000_0000, 1'b1);
        queue_load(REQ_LOAD_B, 32'h0000_0004, 16'h5555, 32'h7fff_ffff, 1'b0);
        queue_start(32'h0000_0000, 32'hffff_fff0, 1'b0);
        // List A alone
        queue_load(REQ_LOAD_A, 32'h0000_0001, 16'h0001, 32'hffff_fff0, 1'b0);
        queue_load(REQ_LOAD_A, 32'h0000_0002, 16'h0002, 32'h0000_0010, 1'b0);
        queue_start(32'h8000_0000, 32'hffff_ffff, 1'b0);
        // Unsorted loads: emitted in head-compare order
        queue_load(REQ_LOAD_A, 32'd50, 16'h0101, 32'h0000_1000, 1'b0);
        queue_load(REQ_LOAD_A, 32'd10, 16'h0202, 32'h0000_0800, 1'b0);
        queue_load(REQ_LOAD_A, 32'd60, 16'h0303, 32'h0000_2000, 1'b0);
        queue_load(REQ_LOAD_B, 32'd20, 16'h0404, 32'h0001_0000, 1'b0);
        queue_load(REQ_LOAD_B, 32'd55, 16'h0505, 32'h0000_ffff, 1'b0);
        queue_start(32'h0000_0100, 32'h0000_0200, 1'b0);
        // Ignored selector between a load and its start
        queue_load(REQ_LOAD_A, 32'd9, 16'h0909, 32'h0000_0009, 1'b0);
        queue_item(REQ_UNUSED, 32'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        queue_start(32'h0000_0001, 32'h0000_0002, 1'b0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait_for_drain();

        // Random phases: sender idles 25 / receiver 47, then swapped, then none.
        // The second phase opens with both lists full and list B
        // overflowing (largest merge).
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 47;
                end
                1: begin
                    send_idle_pct = 47;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            batch_loads = 0;
            if (phase == 1) queue_merge_batch(DEPTH, DEPTH + 1);
            while (batch_loads < 8) queue_merge_batch(list_len(), list_len());
            wait_for_drain();
        end

        // Let any stray result show up before judging
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (bad_results == 0 && merged_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
